// ===== rtl/rcm_pkg.sv =====
`default_nettype none
package rcm_pkg;
    localparam int NUM_RESOURCES_DEF = 16;
    localparam int RING_DEPTH_DEF    = 32;

    localparam logic [2:0] OP_ACQUIRE  = 3'd0;
    localparam logic [2:0] OP_RELEASE  = 3'd1;
    localparam logic [2:0] OP_FAIL     = 3'd2;
    localparam logic [2:0] OP_DEADLOCK = 3'd3;
    localparam logic [2:0] OP_CHECK    = 3'd4;
    localparam logic [2:0] OP_SAMPLE   = 3'd5;
    localparam logic [2:0] OP_READ     = 3'd6;
    localparam logic [2:0] OP_HISTORY  = 3'd7;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_INTERVAL  = 2'd2;

    localparam logic [6:0]  PCT_MAX = 7'd100;
    localparam logic [31:0] THRESHOLD_RST = 32'd80;
    localparam logic [31:0] LIMIT_RST     = 32'd10;
    localparam logic [31:0] INTERVAL_RST  = 32'd100;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch input item
        logic update;    // apply counter update
        logic div_start; // load divider
        logic div_step;  // one quotient bit
        logic div_sel;   // 0 percent, 1 wait, 2 hold (with sel2)
        logic div_sel2;
        logic div_store; // store quotient
        logic pct_apply; // write percent and check flags
        logic ring_rd;   // issue history read
        logic finish;    // load output registers
    } rcm_cmd_t;

    typedef struct packed {
        logic div_done;
    } rcm_sts_t;
endpackage
`default_nettype wire

// ===== rtl/rcm_ram.sv =====
`default_nettype none
module rcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/rcm_ctrl.sv =====
`default_nettype none
module rcm_ctrl
    import rcm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rcm_cmd_t      cmd,
    input  wire rcm_sts_t sts
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UPD   = 4'd1;
    localparam logic [3:0] ST_PLD   = 4'd2;
    localparam logic [3:0] ST_PDIV  = 4'd3;
    localparam logic [3:0] ST_PAPP  = 4'd4;
    localparam logic [3:0] ST_WLD   = 4'd5;
    localparam logic [3:0] ST_WDIV  = 4'd6;
    localparam logic [3:0] ST_HLD   = 4'd7;
    localparam logic [3:0] ST_HDIV  = 4'd8;
    localparam logic [3:0] ST_RRD   = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    assign m_valid = mv_reg;
    // output register frees once taken; a new item may start while it waits
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        mv_next       = mv_reg && !m_ready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_PLD;
            end
            ST_PLD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_PDIV;
            end
            ST_PDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ST_PAPP;
            end
            ST_PAPP: begin
                cmd.pct_apply = 1'b1;
                state_next    = ST_WLD;
            end
            ST_WLD: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_WDIV;
            end
            ST_WDIV: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = 1'b1;
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_HLD;
                end
            end
            ST_HLD: begin
                cmd.div_start = 1'b1;
                cmd.div_sel2  = 1'b1;
                state_next    = ST_HDIV;
            end
            ST_HDIV: begin
                cmd.div_step = 1'b1;
                cmd.div_sel2 = 1'b1;
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_RRD;
                end
            end
            ST_RRD: begin
                cmd.ring_rd = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rcm_dp.sv =====
`default_nettype none
module rcm_dp
    import rcm_pkg::*;
#(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [2:0]  s_op,
    input  wire logic [3:0]  s_resource,
    input  wire logic [31:0] s_amount,
    input  wire logic [31:0] s_now_ticks,
    input  wire logic [4:0]  s_age,
    input  wire rcm_cmd_t    cmd,
    output rcm_sts_t         sts,
    output logic             m_alert_raised,
    output logic             m_contention_warning,
    output logic [6:0]       m_usage_percent,
    output logic [6:0]       m_peak_percent,
    output logic [31:0]      m_acquisitions,
    output logic [31:0]      m_failures,
    output logic [31:0]      m_avg_wait,
    output logic [31:0]      m_avg_hold,
    output logic [31:0]      m_deadlocks,
    output logic [6:0]       m_history_sample,
    output logic             m_history_valid
);
    localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int HW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int IW = HW + 6;

    logic [6:0]  thr_reg;
    logic [31:0] lim_reg, ivl_reg;

    logic [31:0] acq_reg  [NUM_RESOURCES];
    logic [31:0] fail_reg [NUM_RESOURCES];
    logic [31:0] wsum_reg [NUM_RESOURCES];
    logic [31:0] hsum_reg [NUM_RESOURCES];
    logic [31:0] dl_reg   [NUM_RESOURCES];
    logic [31:0] last_reg [NUM_RESOURCES];
    logic [6:0]  cur_reg  [NUM_RESOURCES];
    logic [6:0]  peak_reg [NUM_RESOURCES];
    logic        alrt_reg [NUM_RESOURCES];
    logic [HW-1:0] head_reg [NUM_RESOURCES];
    logic [FW-1:0] fill_reg [NUM_RESOURCES];

    logic [2:0]  op_reg;
    logic [RW-1:0] r_reg;
    logic        oor_reg;
    logic [31:0] amt_reg, now_reg;
    logic [4:0]  age_reg;

    // shared restoring divider, 33-bit divisor for the percent case
    logic [39:0] num_reg;
    logic [32:0] den_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_len;
    logic [31:0] avgw_reg, avgh_reg;
    logic        alert_new_reg, warn_reg;
    logic        wr_sel_reg;
    logic        hv_reg;

    logic [34:0] trial;
    logic [33:0] rem_sh;
    logic [31:0] q_last;
    logic [32:0] total;
    logic [6:0]  ring_rdata;
    logic [6:0]  hist_q;
    logic        hv;
    logic [IW-1:0] rd_sum;
    logic [HW-1:0] ring_rd_idx;
    logic [RW+HW-1:0] ring_raddr, ring_waddr;
    logic        samp_we;
    logic [6:0]  pct;

    assign total  = {1'b0, acq_reg[r_reg]} + {1'b0, fail_reg[r_reg]};
    assign rem_sh = {rem_reg, num_reg[39]};
    assign trial  = {1'b0, rem_sh} - {2'b0, den_reg};
    // quotient including the bit decided in the last step
    assign q_last = {num_reg[30:0], !trial[34]};
    assign sts.div_done = (cnt_reg == 6'd1);
    assign cnt_len = (cmd.div_sel || cmd.div_sel2) ? 6'd32 : 6'd40;
    assign pct = (num_reg[39:0] > 40'd100) ? PCT_MAX : num_reg[6:0];
    // age is below the fill count whenever the read counts, so one wrap suffices
    assign rd_sum = IW'(head_reg[r_reg]) + IW'(RING_DEPTH - 1) - IW'(age_reg);
    assign ring_rd_idx = (rd_sum >= IW'(RING_DEPTH)) ? HW'(rd_sum - IW'(RING_DEPTH))
                                                     : rd_sum[HW-1:0];
    assign ring_raddr = {r_reg, ring_rd_idx};
    assign ring_waddr = {r_reg, head_reg[r_reg]};
    assign samp_we = cmd.update && !oor_reg && (op_reg == OP_SAMPLE)
                     && ((now_reg - last_reg[r_reg]) >= ivl_reg);

    rcm_ram #(.WIDTH(7), .DEPTH(1 << (RW + HW))) u_ring (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (ring_waddr),
        .wdata (cur_reg[r_reg]),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign hist_q = ring_rdata;
    assign hv = (op_reg == OP_HISTORY) && !oor_reg
                && ({27'd0, age_reg} < 32'(fill_reg[r_reg]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RST[6:0];
            lim_reg <= LIMIT_RST;
            ivl_reg <= INTERVAL_RST;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                acq_reg[i] <= '0; fail_reg[i] <= '0; wsum_reg[i] <= '0;
                hsum_reg[i] <= '0; dl_reg[i] <= '0; last_reg[i] <= '0;
                cur_reg[i] <= '0; peak_reg[i] <= '0; alrt_reg[i] <= 1'b0;
                head_reg[i] <= '0; fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_data[6:0];
                    CFG_LIMIT:     lim_reg <= cfg_data;
                    CFG_INTERVAL:  ivl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.update && !oor_reg) begin
                case (op_reg)
                    OP_ACQUIRE: begin
                        acq_reg[r_reg]  <= acq_reg[r_reg] + 32'd1;
                        wsum_reg[r_reg] <= wsum_reg[r_reg] + amt_reg;
                    end
                    OP_RELEASE:  hsum_reg[r_reg] <= hsum_reg[r_reg] + amt_reg;
                    OP_FAIL:     fail_reg[r_reg] <= fail_reg[r_reg] + 32'd1;
                    OP_DEADLOCK: dl_reg[r_reg] <= dl_reg[r_reg] + 32'd1;
                    default: ;
                endcase
                if (samp_we) begin
                    head_reg[r_reg] <= (head_reg[r_reg] == HW'(RING_DEPTH - 1)) ? '0
                                       : head_reg[r_reg] + HW'(1);
                    if (fill_reg[r_reg] < FW'(RING_DEPTH))
                        fill_reg[r_reg] <= fill_reg[r_reg] + FW'(1);
                    last_reg[r_reg] <= now_reg;
                end
            end
            if (cmd.pct_apply && !oor_reg && op_reg == OP_CHECK) begin
                if (total != 33'd0) begin
                    cur_reg[r_reg] <= pct;
                    if (pct > peak_reg[r_reg]) peak_reg[r_reg] <= pct;
                    if (!alrt_reg[r_reg] && pct >= thr_reg) alrt_reg[r_reg] <= 1'b1;
                end else if (!alrt_reg[r_reg] && cur_reg[r_reg] >= thr_reg) begin
                    alrt_reg[r_reg] <= 1'b1;
                end
            end
        end
    end

    // item payload, divider, flags and output registers; no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            oor_reg <= ({28'd0, s_resource} >= 32'(NUM_RESOURCES));
            r_reg   <= RW'(s_resource);
            amt_reg <= s_amount;
            now_reg <= s_now_ticks;
            age_reg <= s_age;
            alert_new_reg <= 1'b0;
            warn_reg      <= 1'b0;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            cnt_reg <= cnt_len;
            wr_sel_reg <= cmd.div_sel;
            if (cmd.div_sel) begin
                num_reg <= {wsum_reg[r_reg], 8'd0};
                den_reg <= {1'b0, acq_reg[r_reg]};
            end else if (cmd.div_sel2) begin
                num_reg <= {hsum_reg[r_reg], 8'd0};
                den_reg <= {1'b0, acq_reg[r_reg]};
            end else begin
                // fails*100 fits in 39 bits
                num_reg <= 40'({fail_reg[r_reg], 6'd0}) + 40'({fail_reg[r_reg], 5'd0})
                           + 40'({fail_reg[r_reg], 2'd0});
                den_reg <= total;
            end
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (!trial[34]) begin
                rem_reg <= trial[32:0];
                num_reg <= {num_reg[38:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[32:0];
                num_reg <= {num_reg[38:0], 1'b0};
            end
        end
        if (cmd.div_store) begin
            if (wr_sel_reg) avgw_reg <= (acq_reg[r_reg] == 32'd0) ? 32'd0 : q_last;
            else            avgh_reg <= (acq_reg[r_reg] == 32'd0) ? 32'd0 : q_last;
        end
        if (cmd.pct_apply && !oor_reg && op_reg == OP_CHECK) begin
            alert_new_reg <= !alrt_reg[r_reg]
                             && (((total != 33'd0) ? pct : cur_reg[r_reg]) >= thr_reg);
            warn_reg <= (fail_reg[r_reg] >= lim_reg);
        end
        if (cmd.ring_rd) begin
            hv_reg <= hv;
        end
        if (cmd.finish) begin
            m_alert_raised       <= alert_new_reg;
            m_contention_warning <= warn_reg;
            m_usage_percent      <= oor_reg ? 7'd0 : cur_reg[r_reg];
            m_peak_percent       <= oor_reg ? 7'd0 : peak_reg[r_reg];
            m_acquisitions       <= oor_reg ? 32'd0 : acq_reg[r_reg];
            m_failures           <= oor_reg ? 32'd0 : fail_reg[r_reg];
            m_avg_wait           <= oor_reg ? 32'd0 : avgw_reg;
            m_avg_hold           <= oor_reg ? 32'd0 : avgh_reg;
            m_deadlocks          <= oor_reg ? 32'd0 : dl_reg[r_reg];
            m_history_sample     <= hv_reg ? hist_q : 7'd0;
            m_history_valid      <= hv_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/resource_contention_monitor_unit.sv =====
`default_nettype none
// resource contention monitor: one result item per input item
// each item runs a 40-step percent divide, then two 32-step average divides on
//   one divider; a new item is accepted only after the previous one has loaded
//   the output register, and that load waits while an older result waits for m_ready
// reset: aresetn synchronous active low; counters cleared, registers to defaults,
//   history ring contents undefined until written
module resource_contention_monitor_unit
    import rcm_pkg::*;
#(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [3:0]  s_resource,
    input  wire logic [31:0] s_amount,
    input  wire logic [31:0] s_now_ticks,
    input  wire logic [4:0]  s_age,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_alert_raised,
    output logic             m_contention_warning,
    output logic [6:0]       m_usage_percent,
    output logic [6:0]       m_peak_percent,
    output logic [31:0]      m_acquisitions,
    output logic [31:0]      m_failures,
    output logic [31:0]      m_avg_wait,
    output logic [31:0]      m_avg_hold,
    output logic [31:0]      m_deadlocks,
    output logic [6:0]       m_history_sample,
    output logic             m_history_valid
);
    rcm_cmd_t cmd;
    rcm_sts_t sts;

    // sequencer: update, percent divide, average divides, ring read, output
    rcm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    // per-resource counters, shared divider, history ring and output register
    rcm_dp #(.NUM_RESOURCES(NUM_RESOURCES), .RING_DEPTH(RING_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_op(s_op), .s_resource(s_resource), .s_amount(s_amount),
        .s_now_ticks(s_now_ticks), .s_age(s_age),
        .cmd(cmd), .sts(sts),
        .m_alert_raised(m_alert_raised),
        .m_contention_warning(m_contention_warning),
        .m_usage_percent(m_usage_percent), .m_peak_percent(m_peak_percent),
        .m_acquisitions(m_acquisitions), .m_failures(m_failures),
        .m_avg_wait(m_avg_wait), .m_avg_hold(m_avg_hold),
        .m_deadlocks(m_deadlocks),
        .m_history_sample(m_history_sample), .m_history_valid(m_history_valid)
    );
endmodule
`default_nettype wire

// ===== bench/tb_resource_contention_monitor_unit.sv =====
`default_nettype none
module tb_resource_contention_monitor_unit;
    import rcm_pkg::*;

    localparam int NRES  = 16;
    localparam int DEPTH = 32;

    // one event item as the sender sees it
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  res;
        logic [31:0] amount;
        logic [31:0] now;
        logic [4:0]  age;
    } event_t;

    // one monitor report
    typedef struct packed {
        logic        alert;
        logic        warn;
        logic [6:0]  usage;
        logic [6:0]  peak;
        logic [31:0] acq;
        logic [31:0] fails;
        logic [31:0] avg_wait;
        logic [31:0] avg_hold;
        logic [31:0] dl;
        logic [6:0]  hist;
        logic        hvalid;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_THRESHOLD;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_op = OP_READ;
    logic [3:0] s_resource = '0;
    logic [31:0] s_amount = '0;
    logic [31:0] s_now_ticks = '0;
    logic [4:0] s_age = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_alert_raised, m_contention_warning, m_history_valid;
    logic [6:0] m_usage_percent, m_peak_percent, m_history_sample;
    logic [31:0] m_acquisitions, m_failures, m_avg_wait, m_avg_hold, m_deadlocks;

    always #10 aclk = ~aclk;

    resource_contention_monitor_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_resource(s_resource),
        .s_amount(s_amount), .s_now_ticks(s_now_ticks), .s_age(s_age),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_alert_raised(m_alert_raised), .m_contention_warning(m_contention_warning),
        .m_usage_percent(m_usage_percent), .m_peak_percent(m_peak_percent),
        .m_acquisitions(m_acquisitions), .m_failures(m_failures),
        .m_avg_wait(m_avg_wait), .m_avg_hold(m_avg_hold), .m_deadlocks(m_deadlocks),
        .m_history_sample(m_history_sample), .m_history_valid(m_history_valid)
    );

    // shadow of the per-resource monitor state
    logic [31:0] acq_cnt [NRES];
    logic [31:0] fail_cnt [NRES];
    logic [31:0] wait_tot [NRES];
    logic [31:0] hold_tot [NRES];
    logic [31:0] dl_cnt [NRES];
    logic [6:0]  usage_now [NRES];
    logic [6:0]  usage_peak [NRES];
    logic        alert_set [NRES];
    logic [31:0] last_tick [NRES];
    int          head [NRES];
    int          fill [NRES];
    logic [6:0]  hist_ring [NRES][DEPTH];
    logic [6:0]  threshold;
    logic [31:0] fail_limit;
    logic [31:0] interval;

    event_t  pending_events[$];
    report_t expected_reports[$];
    bit      failed = 1'b0;
    bit      calm = 1'b0;       // no idling in the last part
    bit      sender_hold = 1'b0;
    int      accepted = 0;
    int      queued = 0;
    int      gap_left = 0;
    int      stall_left = 0;

    // works out the report for one accepted event and advances the shadow state
    function automatic report_t monitor_event(event_t e);
        report_t rp;
        logic [63:0] total, pct;
        int r, slot;
        rp = '0;
        r = e.res;
        case (e.op)
            OP_ACQUIRE: begin
                acq_cnt[r] += 1;
                wait_tot[r] += e.amount;
            end
            OP_RELEASE: hold_tot[r] += e.amount;
            OP_FAIL: fail_cnt[r] += 1;
            OP_DEADLOCK: dl_cnt[r] += 1;
            OP_CHECK: begin
                total = 64'(acq_cnt[r]) + 64'(fail_cnt[r]);
                if (total != 0) begin
                    pct = (64'(fail_cnt[r]) * 100) / total;
                    if (pct > 100) pct = 100;
                    usage_now[r] = pct[6:0];
                    if (usage_now[r] > usage_peak[r]) usage_peak[r] = usage_now[r];
                end
                if (!alert_set[r] && usage_now[r] >= threshold) begin
                    alert_set[r] = 1'b1;
                    rp.alert = 1'b1;
                end
                rp.warn = fail_cnt[r] >= fail_limit;
            end
            OP_SAMPLE: begin
                if (32'(e.now - last_tick[r]) >= interval) begin
                    hist_ring[r][head[r]] = usage_now[r];
                    head[r] = (head[r] + 1) % DEPTH;
                    if (fill[r] < DEPTH) fill[r]++;
                    last_tick[r] = e.now;
                end
            end
            OP_HISTORY: begin
                if (e.age < fill[r]) begin
                    slot = (head[r] + 2 * DEPTH - 1 - e.age) % DEPTH;
                    rp.hist = hist_ring[r][slot];
                    rp.hvalid = 1'b1;
                end
            end
            default: ;
        endcase
        rp.usage = usage_now[r];
        rp.peak = usage_peak[r];
        rp.acq = acq_cnt[r];
        rp.fails = fail_cnt[r];
        rp.avg_wait = acq_cnt[r] != 0 ? wait_tot[r] / acq_cnt[r] : 32'd0;
        rp.avg_hold = acq_cnt[r] != 0 ? hold_tot[r] / acq_cnt[r] : 32'd0;
        rp.dl = dl_cnt[r];
        return rp;
    endfunction

    // sender: one item at a time from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_reports.push_back(monitor_event({s_op, s_resource, s_amount,
                                                          s_now_ticks, s_age}));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 13) - 1;
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0 && !sender_hold) begin
                    event_t e;
                    e = pending_events.pop_front();
                    s_op <= e.op;
                    s_resource <= e.res;
                    s_amount <= e.amount;
                    s_now_ticks <= e.now;
                    s_age <= e.age;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, checks every report in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                report_t got, want;
                got = {m_alert_raised, m_contention_warning, m_usage_percent,
                       m_peak_percent, m_acquisitions, m_failures, m_avg_wait,
                       m_avg_hold, m_deadlocks, m_history_sample, m_history_valid};
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.alert !== want.alert || got.warn !== want.warn ||
                        got.usage !== want.usage || got.peak !== want.peak ||
                        got.acq !== want.acq || got.fails !== want.fails ||
                        got.avg_wait !== want.avg_wait || got.avg_hold !== want.avg_hold ||
                        got.dl !== want.dl || got.hist !== want.hist ||
                        got.hvalid !== want.hvalid) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_event(logic [2:0] op, logic [3:0] res, logic [31:0] amount,
                             logic [31:0] now, logic [4:0] age);
        pending_events.push_back({op, res, amount, now, age});
        queued++;
    endtask

    // waits until every queued item has been answered, then lets the block settle
    task automatic drain();
        while (accepted != queued || expected_reports.size() != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    // one write, then cfg_we low before returning so back-to-back writes never collide
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: threshold = value[6:0];
            CFG_LIMIT: fail_limit = value;
            CFG_INTERVAL: interval = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // mostly well-formed traffic on a few hot resources, with full-range noise
    task automatic random_events(int count, int hot);
        logic [3:0] r;
        logic [2:0] op;
        logic [31:0] amt;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, hot));
            op = 3'($urandom);
            case ($urandom_range(0, 3))
                0: amt = $urandom;
                1: amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: amt = $urandom_range(0, 1000);
            endcase
            add_event(op, r, amt, $urandom_range(0, 3) == 0 ? $urandom
                                                           : $urandom_range(0, 400),
                      5'($urandom));
        end
    endtask

    initial begin
        for (int r = 0; r < NRES; r++) begin
            acq_cnt[r] = 0; fail_cnt[r] = 0; wait_tot[r] = 0; hold_tot[r] = 0;
            dl_cnt[r] = 0; usage_now[r] = 0; usage_peak[r] = 0; alert_set[r] = 0;
            last_tick[r] = 0; head[r] = 0; fill[r] = 0;
        end
        threshold = 7'd80;
        fail_limit = 32'd10;
        interval = 32'd100;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: check with no attempts, extremes, every op, tick wrap
        add_event(OP_CHECK, 4'd0, 0, 0, 0);
        add_event(OP_HISTORY, 4'd0, 0, 0, 5'd0);
        add_event(OP_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 0, 0);
        add_event(OP_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 0, 0);
        add_event(OP_RELEASE, 4'd15, 32'hFFFF_FFFF, 0, 0);
        add_event(OP_FAIL, 4'd15, 0, 0, 0);
        add_event(OP_DEADLOCK, 4'd15, 0, 0, 0);
        add_event(OP_CHECK, 4'd15, 0, 0, 0);
        add_event(OP_READ, 4'd15, 0, 0, 0);
        add_event(OP_FAIL, 4'd1, 0, 0, 0);
        add_event(OP_CHECK, 4'd1, 0, 0, 0);
        add_event(OP_SAMPLE, 4'd1, 0, 32'd99, 0);
        add_event(OP_SAMPLE, 4'd1, 0, 32'd100, 0);
        add_event(OP_SAMPLE, 4'd1, 0, 32'h0000_0010, 0); // tick wrap
        add_event(OP_HISTORY, 4'd1, 0, 0, 5'd0);
        add_event(OP_HISTORY, 4'd1, 0, 0, 5'd1);
        add_event(OP_HISTORY, 4'd1, 0, 0, 5'd31);
        drain();

        // zero interval: every sample stores, fills and wraps the ring
        write_reg(CFG_INTERVAL, 32'd0);
        write_reg(CFG_THRESHOLD, 7'd0);
        write_reg(CFG_LIMIT, 32'd0);
        for (int i = 0; i < 36; i++) begin
            add_event(i % 3 == 0 ? OP_FAIL : OP_ACQUIRE, 4'd2, 32'd7, 0, 0);
            add_event(OP_CHECK, 4'd2, 0, 0, 0);
            add_event(OP_SAMPLE, 4'd2, 0, 32'(i), 0);
        end
        for (int a = 0; a < 32; a++) add_event(OP_HISTORY, 4'd2, 0, 0, 5'(a));
        random_events(250, 3);
        drain();

        // other extremes, then a hold-off until all answers are in
        write_reg(CFG_THRESHOLD, 7'd100);
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
        random_events(300, 5);
        repeat (3000) @(posedge aclk);
        sender_hold = 1'b1;
        while (s_valid || expected_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        sender_hold = 1'b0;
        drain();

        write_reg(CFG_THRESHOLD, 7'($urandom_range(20, 70)));
        write_reg(CFG_LIMIT, $urandom_range(1, 6));
        write_reg(CFG_INTERVAL, $urandom_range(1, 150));
        random_events(450, 7);
        drain();

        // last stretch with no idling
        write_reg(CFG_THRESHOLD, 7'd80);
        write_reg(CFG_LIMIT, 32'd10);
        write_reg(CFG_INTERVAL, 32'd100);
        calm = 1'b1;
        random_events(250, 15);
        drain();

        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
